/* design/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 24;
    localparam int unsigned VALUE_W = 21;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned SKIP_W  = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned QCNT_W  = 2;

    localparam logic [CODE_W-1:0]  REPL_WORD  = 24'hFF_FFFF;
    localparam logic [BYTE_W-1:0]  ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0]  LEAD2_MIN  = 8'hC0;
    localparam logic [BYTE_W-1:0]  LEAD2_MAX  = 8'hDF;
    localparam logic [BYTE_W-1:0]  LEAD3_MIN  = 8'hE0;
    localparam logic [BYTE_W-1:0]  LEAD3_MAX  = 8'hEF;
    localparam logic [BYTE_W-1:0]  LEAD4_MIN  = 8'hF0;
    localparam logic [BYTE_W-1:0]  LEAD4_MAX  = 8'hF7;
    localparam logic [BYTE_W-1:0]  CONT_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0]  CONT_MAX   = 8'hBF;
    localparam logic [BYTE_W-1:0]  CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0]  LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0]  LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0]  LEAD4_MASK = 8'h07;

    localparam logic [LEN_W-1:0]   LEN_NONE   = 3'd0;
    localparam logic [LEN_W-1:0]   LEN_2      = 3'd2;
    localparam logic [LEN_W-1:0]   LEN_3      = 3'd3;
    localparam logic [LEN_W-1:0]   LEN_4      = 3'd4;
    localparam logic [LEN_W-1:0]   SEQ_MAX    = 3'd4;
    localparam logic [SKIP_W-1:0]  SKIP_BAD_LEAD = 2'd3;

    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } t_byte_class;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        t_byte_class         cls;
        logic [VALUE_W-1:0]  bits;   // payload bits already masked
        logic                eos;
    } t_item;

endpackage

/* design/u8sd_front.sv */
// Front end: classify each incoming byte and mask out its payload bits.
module u8sd_front (
    input  logic [u8sd_pkg::BYTE_W-1:0] i_byte_value,
    input  logic                        i_end_of_stream,
    output u8sd_pkg::t_item             o_item
);

    always_comb begin
        o_item.eos  = i_end_of_stream;
        o_item.cls  = u8sd_pkg::CLS_BAD;
        o_item.bits = '0;
        if (i_byte_value <= u8sd_pkg::ASCII_MAX) begin
            o_item.cls  = u8sd_pkg::CLS_ASCII;
            o_item.bits = u8sd_pkg::VALUE_W'(i_byte_value);
        end else if (i_byte_value <= u8sd_pkg::CONT_MAX) begin
            o_item.cls  = u8sd_pkg::CLS_CONT;
            o_item.bits = u8sd_pkg::VALUE_W'(i_byte_value & u8sd_pkg::CONT_MASK);
        end else if (i_byte_value <= u8sd_pkg::LEAD2_MAX) begin
            o_item.cls  = u8sd_pkg::CLS_LEAD2;
            o_item.bits = u8sd_pkg::VALUE_W'(i_byte_value & u8sd_pkg::LEAD2_MASK);
        end else if (i_byte_value <= u8sd_pkg::LEAD3_MAX) begin
            o_item.cls  = u8sd_pkg::CLS_LEAD3;
            o_item.bits = u8sd_pkg::VALUE_W'(i_byte_value & u8sd_pkg::LEAD3_MASK);
        end else if (i_byte_value <= u8sd_pkg::LEAD4_MAX) begin
            o_item.cls  = u8sd_pkg::CLS_LEAD4;
            o_item.bits = u8sd_pkg::VALUE_W'(i_byte_value & u8sd_pkg::LEAD4_MASK);
        end
    end

endmodule

/* design/u8sd_queue.sv */
// Two-entry queue of classified items between front end and back end.
module u8sd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8sd_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u8sd_pkg::t_item o_item
);

    u8sd_pkg::t_item                   r_entry [u8sd_pkg::QUEUE_DEPTH];
    logic [u8sd_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [u8sd_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [u8sd_pkg::QCNT_W-1:0]       r_count;
    logic [u8sd_pkg::QCNT_W-1:0]       n_count;

    assign o_full  = (r_count == u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_item;
    end

endmodule

/* design/u8sd_back.sv */
// Back end: sequence state, error swallowing and the output register.
module u8sd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_have_item,
    input  u8sd_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [u8sd_pkg::CODE_W-1:0]  o_code_point,
    output logic                         o_is_replacement
);

    logic [u8sd_pkg::LEN_W-1:0]   r_len,  n_len;
    logic [u8sd_pkg::LEN_W-1:0]   r_taken, n_taken;
    logic [u8sd_pkg::VALUE_W-1:0] r_partial, n_partial;
    logic [u8sd_pkg::SKIP_W-1:0]  r_skip, n_skip;
    logic                         r_out_valid;
    logic [u8sd_pkg::CODE_W-1:0]  r_code;
    logic                         r_repl;

    logic                         emit;
    logic                         emit_repl;
    logic [u8sd_pkg::VALUE_W-1:0] emit_value;
    logic [u8sd_pkg::VALUE_W-1:0] shifted;
    logic [u8sd_pkg::LEN_W-1:0]   taken_inc;

    assign o_pop            = i_have_item && (!r_out_valid || !i_stall);
    assign o_valid          = r_out_valid;
    assign o_code_point     = r_code;
    assign o_is_replacement = r_repl;

    assign shifted   = {r_partial[u8sd_pkg::VALUE_W-7:0], 6'b0} | i_item.bits;
    assign taken_inc = r_taken + 1'b1;

    always_comb begin
        n_len      = r_len;
        n_taken    = r_taken;
        n_partial  = r_partial;
        n_skip     = r_skip;
        emit       = 1'b0;
        emit_repl  = 1'b0;
        emit_value = i_item.bits;
        if (r_skip != '0) begin
            n_skip = r_skip - 1'b1;
        end else if (r_len == u8sd_pkg::LEN_NONE) begin
            case (i_item.cls)
                u8sd_pkg::CLS_ASCII: begin
                    emit = 1'b1;
                end
                u8sd_pkg::CLS_LEAD2, u8sd_pkg::CLS_LEAD3, u8sd_pkg::CLS_LEAD4: begin
                    if (i_item.eos) begin
                        emit      = 1'b1;
                        emit_repl = 1'b1;
                    end else begin
                        n_taken   = u8sd_pkg::LEN_W'(1);
                        n_partial = i_item.bits;
                        n_len     = (i_item.cls == u8sd_pkg::CLS_LEAD2) ? u8sd_pkg::LEN_2 :
                                    (i_item.cls == u8sd_pkg::CLS_LEAD3) ? u8sd_pkg::LEN_3 :
                                                                          u8sd_pkg::LEN_4;
                    end
                end
                default: begin
                    emit      = 1'b1;
                    emit_repl = 1'b1;
                    n_skip    = u8sd_pkg::SKIP_BAD_LEAD;
                end
            endcase
        end else if (i_item.cls == u8sd_pkg::CLS_CONT) begin
            n_partial = shifted;
            n_taken   = taken_inc;
            if (taken_inc >= r_len) begin
                emit       = 1'b1;
                emit_value = shifted;
                n_len      = u8sd_pkg::LEN_NONE;
                n_taken    = '0;
                n_partial  = '0;
            end else if (i_item.eos) begin
                emit      = 1'b1;
                emit_repl = 1'b1;
            end
        end else begin
            // bad byte inside a sequence: swallow until four bytes from the lead are consumed
            emit      = 1'b1;
            emit_repl = 1'b1;
            n_len     = u8sd_pkg::LEN_NONE;
            n_taken   = '0;
            n_partial = '0;
            n_skip    = u8sd_pkg::SKIP_W'(u8sd_pkg::SEQ_MAX - taken_inc);
        end
        // end of stream or a replacement clears the sequence state; end of stream also ends a swallow
        if (i_item.eos || emit_repl) begin
            n_len     = u8sd_pkg::LEN_NONE;
            n_taken   = '0;
            n_partial = '0;
        end
        if (i_item.eos) begin
            n_skip = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= u8sd_pkg::LEN_NONE;
            r_taken     <= '0;
            r_partial   <= '0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_len     <= n_len;
                r_taken   <= n_taken;
                r_partial <= n_partial;
                r_skip    <= n_skip;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_code <= emit_repl ? u8sd_pkg::REPL_WORD : u8sd_pkg::CODE_W'(emit_value);
            r_repl <= emit_repl;
        end
    end

endmodule

/* design/utf8_stream_decoder_core.sv */
// Top level of the streaming UTF-8 decoder: front end, item queue, back end.
//
// Decodes a UTF-8 byte stream, one byte per item, and delivers one code point
// item each time a sequence completes, or the replacement word 0xFFFFFF with
// o_is_replacement set when a bad lead, a bad continuation or a sequence cut
// short by i_end_of_stream is seen. After an error, bytes are swallowed until
// four bytes from the failing lead are consumed; end of stream resets all
// sequence state. Overlong forms and surrogates pass through undecorated.
// Rate: one byte item per clock cycle sustained while i_stall is low. An
// accepted byte is written into the two-entry queue, then popped by the back
// end, which updates the sequence state and loads the output register. The
// back end takes one queued item per cycle whenever the output register is
// empty or being drained, so a stall on the output side backs up through the
// queue and reaches o_stall only once both queue entries are occupied.
module utf8_stream_decoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [u8sd_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic                         i_end_of_stream,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [u8sd_pkg::CODE_W-1:0]  o_code_point,
    output logic                         o_is_replacement
);

    u8sd_pkg::t_item front_item;
    u8sd_pkg::t_item queue_item;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;

    // Classify the incoming byte in the same cycle it arrives.
    u8sd_front u_front (
        .i_byte_value    (i_byte_value),
        .i_end_of_stream (i_end_of_stream),
        .o_item          (front_item)
    );

    // Hold off the sender only while the queue is full.
    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (queue_item)
    );

    // Advance the decoder one queued item per cycle while the output register is empty or being drained.
    u8sd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_have_item      (!q_empty),
        .i_item           (queue_item),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_point     (o_code_point),
        .o_is_replacement (o_is_replacement)
    );

endmodule

/* design/u8sd_checker.sv */
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8sd_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [u8sd_pkg::CODE_W-1:0]  o_code_point,
    input  logic                         o_is_replacement
);

    // A replacement item always carries the replacement word.
    a_repl_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_replacement |-> o_code_point == u8sd_pkg::REPL_WORD)
        else $error("replacement flag without replacement word");

    // A decoded value never exceeds 21 bits.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_replacement |-> o_code_point[23:21] == 3'b000)
        else $error("decoded value wider than 21 bits");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point)
                               && $stable(o_is_replacement))
        else $error("stalled result changed");

    // Reset clears the output valid and the input stall.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_code_point     (o_code_point),
    .o_is_replacement (o_is_replacement)
);

/* tb/utf8_decode_checker.sv */
// Checker for the UTF-8 stream decoder: predicts each code point item and compares it.
module utf8_decode_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_byte_valid,
    input  logic                          i_byte_stall,
    input  logic [u8sd_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic                          i_end_of_stream,
    input  logic                          i_cp_valid,
    input  logic                          i_cp_stall,
    input  logic [u8sd_pkg::CODE_W-1:0]   i_code_point,
    input  logic                          i_is_replacement,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_code_points,
    output int                            o_replacements
);

    typedef struct packed {
        logic [u8sd_pkg::CODE_W-1:0] code;
        logic                        repl;
    } t_decoded;

    // Decoder state as the predictor sees it.
    logic [u8sd_pkg::LEN_W-1:0]   seq_len;
    logic [u8sd_pkg::LEN_W-1:0]   seq_taken;
    logic [u8sd_pkg::VALUE_W-1:0] seq_bits;
    logic [u8sd_pkg::SKIP_W-1:0]  swallow_left;

    t_decoded decoded_q[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_code_points  = 0;
        o_replacements = 0;
    end

    function automatic u8sd_pkg::t_byte_class byte_class(
        input logic [u8sd_pkg::BYTE_W-1:0] b);
        if (b <= u8sd_pkg::ASCII_MAX) return u8sd_pkg::CLS_ASCII;
        if (b >= u8sd_pkg::CONT_MIN && b <= u8sd_pkg::CONT_MAX) return u8sd_pkg::CLS_CONT;
        if (b >= u8sd_pkg::LEAD2_MIN && b <= u8sd_pkg::LEAD2_MAX) return u8sd_pkg::CLS_LEAD2;
        if (b >= u8sd_pkg::LEAD3_MIN && b <= u8sd_pkg::LEAD3_MAX) return u8sd_pkg::CLS_LEAD3;
        if (b >= u8sd_pkg::LEAD4_MIN && b <= u8sd_pkg::LEAD4_MAX) return u8sd_pkg::CLS_LEAD4;
        return u8sd_pkg::CLS_BAD;
    endfunction

    task automatic clear_sequence();
        seq_len      = u8sd_pkg::LEN_NONE;
        seq_taken    = '0;
        seq_bits     = '0;
        swallow_left = '0;
    endtask

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 30) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Advance the predicted state by one byte; flag a code point item when one is due.
    task automatic decode_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic eos,
                               output bit emit, output t_decoded res);
        u8sd_pkg::t_byte_class       cls;
        logic [u8sd_pkg::LEN_W-1:0]  used;
        cls  = byte_class(b);
        emit = 1'b0;
        res  = '0;
        if (swallow_left != 0) begin
            swallow_left = swallow_left - 1'b1;
            if (eos) clear_sequence();
        end else if (seq_len == u8sd_pkg::LEN_NONE) begin
            case (cls)
                u8sd_pkg::CLS_ASCII: begin
                    emit = 1'b1;
                    res  = '{code: {16'h0000, b}, repl: 1'b0};
                    if (eos) clear_sequence();
                end
                u8sd_pkg::CLS_LEAD2, u8sd_pkg::CLS_LEAD3, u8sd_pkg::CLS_LEAD4: begin
                    if (eos) begin
                        // lead byte as the final byte: cut short
                        clear_sequence();
                        emit = 1'b1;
                        res  = '{code: u8sd_pkg::REPL_WORD, repl: 1'b1};
                    end else begin
                        seq_taken = 3'd1;
                        case (cls)
                            u8sd_pkg::CLS_LEAD2: begin
                                seq_len  = u8sd_pkg::LEN_2;
                                seq_bits = u8sd_pkg::VALUE_W'(b & u8sd_pkg::LEAD2_MASK);
                            end
                            u8sd_pkg::CLS_LEAD3: begin
                                seq_len  = u8sd_pkg::LEN_3;
                                seq_bits = u8sd_pkg::VALUE_W'(b & u8sd_pkg::LEAD3_MASK);
                            end
                            default: begin
                                seq_len  = u8sd_pkg::LEN_4;
                                seq_bits = u8sd_pkg::VALUE_W'(b & u8sd_pkg::LEAD4_MASK);
                            end
                        endcase
                    end
                end
                default: begin
                    // bad lead: replace, then swallow three bytes unless the stream ends
                    emit = 1'b1;
                    res  = '{code: u8sd_pkg::REPL_WORD, repl: 1'b1};
                    clear_sequence();
                    if (!eos) swallow_left = u8sd_pkg::SKIP_BAD_LEAD;
                end
            endcase
        end else if (cls == u8sd_pkg::CLS_CONT) begin
            seq_bits  = {seq_bits[u8sd_pkg::VALUE_W-7:0], b[5:0]};
            seq_taken = seq_taken + 1'b1;
            if (seq_taken >= seq_len) begin
                emit = 1'b1;
                res  = '{code: {3'b000, seq_bits}, repl: 1'b0};
                clear_sequence();
            end else if (eos) begin
                emit = 1'b1;
                res  = '{code: u8sd_pkg::REPL_WORD, repl: 1'b1};
                clear_sequence();
            end
        end else begin
            // bad continuation: it counts toward the four bytes from the lead
            used = seq_taken + 1'b1;
            emit = 1'b1;
            res  = '{code: u8sd_pkg::REPL_WORD, repl: 1'b1};
            clear_sequence();
            if (!eos) begin
                swallow_left = (used < u8sd_pkg::SEQ_MAX) ?
                               u8sd_pkg::SKIP_W'(u8sd_pkg::SEQ_MAX - used) : '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        bit       emit;
        t_decoded pred;
        t_decoded want;
        if (!i_rst_n) begin
            clear_sequence();
            decoded_q.delete();
        end else begin
            if (i_byte_valid && !i_byte_stall) begin
                decode_byte(i_byte_value, i_end_of_stream, emit, pred);
                if (emit) decoded_q.push_back(pred);
            end
            if (i_cp_valid && !i_cp_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item code_point=%06h repl=%0b",
                                              i_code_point, i_is_replacement));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_code_point !== want.code)
                        report_mismatch($sformatf("code_point %06h, expected %06h",
                                                  i_code_point, want.code));
                    if (i_is_replacement !== want.repl)
                        report_mismatch($sformatf("is_replacement %0b, expected %0b",
                                                  i_is_replacement, want.repl));
                    if (want.repl) o_replacements++;
                    else o_code_points++;
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

/* tb/tb_utf8_stream_decoder_core.sv */
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus and verdict.
module tb_utf8_stream_decoder_core;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 60;

    logic                          clk;
    logic                          rst_n;
    logic                          byte_valid;
    logic                          byte_stall;
    logic [u8sd_pkg::BYTE_W-1:0]   byte_value;
    logic                          byte_eos;
    logic                          cp_valid;
    logic                          cp_stall;
    logic [u8sd_pkg::CODE_W-1:0]   code_point;
    logic                          is_repl;

    int fail_count;
    int pending;
    int code_points;
    int replacements;
    int bytes_sent;
    int cycles;

    // Knobs set by the main sequence for the byte sender and the code point receiver.
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    utf8_stream_decoder_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (byte_valid),
        .o_stall          (byte_stall),
        .i_byte_value     (byte_value),
        .i_end_of_stream  (byte_eos),
        .o_valid          (cp_valid),
        .i_stall          (cp_stall),
        .o_code_point     (code_point),
        .o_is_replacement (is_repl)
    );

    utf8_decode_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_byte_valid     (byte_valid),
        .i_byte_stall     (byte_stall),
        .i_byte_value     (byte_value),
        .i_end_of_stream  (byte_eos),
        .i_cp_valid       (cp_valid),
        .i_cp_stall       (cp_stall),
        .i_code_point     (code_point),
        .i_is_replacement (is_repl),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_code_points    (code_points),
        .o_replacements   (replacements)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up once the cycle budget is spent.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: drive stall at the falling edge. A hold request wins over
    // random bursts and is counted down here, one cycle per falling edge.
    initial begin
        int burst_left;
        int hold_left;
        cp_stall   = 1'b0;
        burst_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                cp_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                cp_stall <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                // start a stall burst here; burst_left holds the rest of it
                burst_left = $urandom_range(0, 10);
                cp_stall <= 1'b1;
            end else begin
                cp_stall <= 1'b0;
            end
        end
    end

    // Offer one byte item and hold it until accepted. Return at the falling
    // edge after acceptance so the next item can follow back to back.
    task automatic send_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic eos);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_value <= b;
        byte_eos   <= eos;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Build one UTF-8 sequence of random length and payload; now and then
    // corrupt it (bad continuation, bad lead, or plain noise). End of stream
    // lands at random on any byte, which also cuts sequences short.
    task automatic send_sequence();
        logic [u8sd_pkg::BYTE_W-1:0] seq [4];
        int len;
        int roll;
        int k;
        len = $urandom_range(1, 4);
        for (k = 1; k < 4; k++) begin
            seq[k] = u8sd_pkg::CONT_MIN | (8'($urandom) & u8sd_pkg::CONT_MASK);
        end
        case (len)
            1:       seq[0] = 8'($urandom_range(0, 127));
            2:       seq[0] = u8sd_pkg::LEAD2_MIN | (8'($urandom) & u8sd_pkg::LEAD2_MASK);
            3:       seq[0] = u8sd_pkg::LEAD3_MIN | (8'($urandom) & u8sd_pkg::LEAD3_MASK);
            default: seq[0] = u8sd_pkg::LEAD4_MIN | (8'($urandom) & u8sd_pkg::LEAD4_MASK);
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 8 && len > 1) begin
            seq[$urandom_range(1, len - 1)] = 8'($urandom);
        end else if (roll < 12) begin
            seq[0] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                 : 8'($urandom_range(8'hF8, 8'hFF));
        end else if (roll < 16) begin
            seq[0] = 8'($urandom);
        end
        for (k = 0; k < len; k++) send_byte(seq[k], $urandom_range(0, 29) == 0);
    endtask

    initial begin
        byte_valid = 1'b0;
        byte_value = '0;
        byte_eos   = 1'b0;
        rst_n      = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed: ASCII extremes and the largest value of each length
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        // bad lead at the top of the range, then three swallowed bytes of any kind
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC0, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'hF0, 1'b0);
        // bad continuation after a three-byte lead: swallow two more
        send_byte(8'hE0, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0); send_byte(8'h80, 1'b0);
        // sequence cut short by end of stream, and a lead as the final byte
        send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b1);
        send_byte(8'hC2, 1'b1);
        // bad lead on the final byte: nothing left to swallow
        send_byte(8'h80, 1'b1);
        send_byte(8'h41, 1'b0);
        // end of stream in the middle of a swallow clears it
        send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b1);
        send_byte(8'h42, 1'b0);

        // Random traffic with idling on both sides
        while (bytes_sent < 500) send_sequence();

        // Hold the receiver off and keep offering items back to back until
        // the decoder backs up and stalls its input
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
        repeat (12) send_sequence();
        tx_idle_on = 1'b1;

        // Pause the sender until every predicted item has come out
        byte_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);

        while (bytes_sent < 1300) send_sequence();

        // Last stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (bytes_sent < 1500) send_sequence();
        byte_valid <= 1'b0;

        // Drain, then wait for any stray item to show up
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d bytes with idling, a long receiver hold and a full drain;",
                 bytes_sent);
        $display("%0d decoded code points and %0d replacement words checked",
                 code_points, replacements);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/u8sd_pkg.sv
design/u8sd_front.sv
design/u8sd_queue.sv
design/u8sd_back.sv
design/utf8_stream_decoder_core.sv
design/u8sd_checker.sv
tb/utf8_decode_checker.sv
tb/tb_utf8_stream_decoder_core.sv
